@@ sv/assert_macros.svh @@
// Assertion macros shared by the dispatcher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ptd_pkg.sv @@
// Types, constants and helpers for the periodic task dispatcher
package ptd_pkg;

    localparam int MAX_TASKS    = 8;
    localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int RESULT_LIMIT = 8;
    localparam int PERIOD_W     = 32;
    localparam int TICK_W       = 32;
    localparam int BIT_W        = $clog2(TICK_W);
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        MODE_TICK       = 2'd0,
        MODE_CREATE     = 2'd1,
        MODE_SET_ACTIVE = 2'd2,
        MODE_SET_PERIOD = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        mode_t                op;
        logic [IDX_W-1:0]     idx;
        logic                 handler_present;
        logic [PERIOD_W-1:0]  period;
        logic                 active;
    } cmd_t;

    // queue status seen by the front and the checks
    typedef struct packed {
        logic full;
        logic empty;
        logic pop;
    } q_stat_t;

    // back-end status seen by the checks
    typedef struct packed {
        logic              tick_done;
        logic [TICK_W-1:0] tick_count;
    } bk_stat_t;

    function automatic logic [2:0] to_due_id(input logic [IDX_W-1:0] idx);
        logic [IDX_W+2:0] ext;
        ext = {3'b000, idx};
        return ext[2:0];
    endfunction

endpackage

@@ sv/ptd_ram.sv @@
// Generic single-port-write, registered-read RAM
module ptd_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ptd_front.sv @@
// Front end: accepts input items, drops table writes with out-of-range ids, builds queue commands
module ptd_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           mode,
    input  logic [7:0]           task_id,
    input  logic                 handler_present,
    input  logic [31:0]          period,
    input  logic                 active,
    input  ptd_pkg::q_stat_t     q_stat,
    output logic                 push,
    output ptd_pkg::cmd_t        push_cmd
);
    import ptd_pkg::*;

    mode_t op;
    logic  in_range;

    assign op       = mode_t'(mode);
    assign in_range = ({1'b0, task_id} < 9'(MAX_TASKS));
    assign in_ready = !q_stat.full;

    // ticks always go through; table writes only for ids inside the table
    assign push = in_valid && in_ready && ((op == MODE_TICK) || in_range);

    always_comb
    begin
        push_cmd.op              = op;
        push_cmd.idx             = task_id[IDX_W-1:0];
        push_cmd.handler_present = handler_present;
        push_cmd.period          = period;
        push_cmd.active          = active;
    end

endmodule

@@ sv/ptd_cmd_fifo.sv @@
// Short command queue between front end and back end
module ptd_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ptd_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output ptd_pkg::cmd_t     head_cmd,
    output logic              head_valid,
    output ptd_pkg::q_stat_t  q_stat
);
    import ptd_pkg::*;

    cmd_t                 fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;
    logic                 full, empty;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = fifo_mem_reg[rd_ptr_reg];
    assign head_valid   = !empty;
    assign q_stat.full  = full;
    assign q_stat.empty = empty;
    assign q_stat.pop   = pop;

endmodule

@@ sv/ptd_back.sv @@
// Back end: task table, serial modulo per task, ordered result emission
module ptd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  ptd_pkg::cmd_t       cmd,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          due_task,
    output logic                last,
    output ptd_pkg::bk_stat_t   bk_stat
);
    import ptd_pkg::*;

    back_state_t            state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [MAX_TASKS-1:0]   present_reg, present_next;
    logic [MAX_TASKS-1:0]   active_reg, active_next;
    logic [MAX_TASKS-1:0]   due_reg, due_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [PERIOD_W-1:0]    div_reg, div_next;
    logic [PERIOD_W-1:0]    rem_reg, rem_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [2:0]             emit_cnt_reg, emit_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             due_task_reg, due_task_next;
    logic                   last_reg, last_next;

    logic                   ram_we;
    logic [PERIOD_W-1:0]    ram_rdata;
    logic                   idx_last;
    logic                   eligible;
    logic [PERIOD_W:0]      rem_sh;
    logic [PERIOD_W:0]      rem_sub;
    logic                   rem_ge;
    logic [PERIOD_W-1:0]    rem_new;
    logic                   slot_free;
    logic [MAX_TASKS-1:0]   due_clr;
    logic                   emit_last;

    ptd_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (MAX_TASKS)
    ) u_period_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (cmd.idx),
        .wr_data (cmd.period),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    assign idx_last  = (idx_reg == IDX_W'(MAX_TASKS - 1));
    assign eligible  = present_reg[idx_reg] && active_reg[idx_reg];
    assign slot_free = !out_valid_reg || out_ready;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
    assign ram_we    = cmd_pop && (cmd.op inside {MODE_CREATE, MODE_SET_PERIOD});

    // one restoring-division step: remainder only
    assign rem_sh  = {rem_reg, tick_reg[bit_reg]};
    assign rem_ge  = (rem_sh >= {1'b0, div_reg});
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign rem_new = rem_ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];

    always_comb
    begin
        due_clr          = due_reg;
        due_clr[idx_reg] = 1'b0;
        emit_last        = (due_clr == '0) || (emit_cnt_reg == 3'(RESULT_LIMIT - 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.op == MODE_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (eligible)
                begin
                    state_next = ST_LOAD;
                end
                else if (idx_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_LOAD:
            begin
                if (ram_rdata != '0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = idx_last ? ST_EMIT : ST_SCAN;
                end
            end
            ST_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = idx_last ? ST_EMIT : ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (due_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next       = idx_reg;
        present_next   = present_reg;
        active_next    = active_reg;
        due_next       = due_reg;
        tick_next      = tick_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        due_task_next  = due_task_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        MODE_TICK:
                        begin
                            idx_next      = '0;
                            due_next      = '0;
                            emit_cnt_next = '0;
                        end
                        MODE_CREATE:
                        begin
                            present_next[cmd.idx] = cmd.handler_present;
                            active_next[cmd.idx]  = cmd.active;
                        end
                        MODE_SET_ACTIVE:
                        begin
                            active_next[cmd.idx] = cmd.active;
                        end
                        default:
                        begin
                            // period goes to the RAM
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!eligible)
                begin
                    idx_next = idx_last ? '0 : idx_reg + 1'b1;
                end
            end
            ST_LOAD:
            begin
                div_next = ram_rdata;
                rem_next = '0;
                bit_next = BIT_W'(TICK_W - 1);
                if (ram_rdata == '0)
                begin
                    idx_next = idx_last ? '0 : idx_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_new;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    due_next[idx_reg] = (rem_new == '0);
                    idx_next          = idx_last ? '0 : idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (due_reg == '0)
                begin
                    tick_next = tick_reg + 1'b1;
                end
                else if (!due_reg[idx_reg])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    due_task_next  = to_due_id(idx_reg);
                    last_next      = emit_last;
                    emit_cnt_next  = emit_cnt_reg + 1'b1;
                    due_next       = emit_last ? '0 : due_clr;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            present_reg   <= '0;
            active_reg    <= '0;
            due_reg       <= '0;
            tick_reg      <= '0;
            bit_reg       <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            present_reg   <= present_next;
            active_reg    <= active_next;
            due_reg       <= due_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        due_task_reg <= due_task_next;
        last_reg     <= last_next;
    end

    assign out_valid          = out_valid_reg;
    assign due_task           = due_task_reg;
    assign last               = last_reg;
    assign bk_stat.tick_done  = (state_reg == ST_EMIT) && (due_reg == '0);
    assign bk_stat.tick_count = tick_reg;

endmodule

@@ sv/periodic_task_dispatcher_core.sv @@
// A table write is applied at the edge where the back end pops it from the queue, which it
// does only while idle. A tick is popped, then each task is visited in id order: skipped if
// absent or suspended, period loaded and skipped if zero, else loaded and put through the
// bit-serial modulo; then the due ids are emitted in ascending order as the output takes them.
// Input transfers continue into the 4-entry queue while a tick is being worked.
// Reset (rst_n, async low) clears the task flags, tick count, queue and output valid.
`include "assert_macros.svh"

module periodic_task_dispatcher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  task_id,
    input  logic        handler_present,
    input  logic [31:0] period,
    input  logic        active,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  due_task,
    output logic        last
);
    import ptd_pkg::*;

    logic     push;
    cmd_t     push_cmd;
    cmd_t     head_cmd;
    logic     head_valid;
    logic     cmd_pop;
    q_stat_t  q_stat;
    bk_stat_t bk_stat;

    ptd_front u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .task_id         (task_id),
        .handler_present (handler_present),
        .period          (period),
        .active          (active),
        .q_stat          (q_stat),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    ptd_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (cmd_pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .q_stat     (q_stat)
    );

    ptd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .due_task  (due_task),
        .last      (last),
        .bk_stat   (bk_stat)
    );

    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_stat.pop, !q_stat.empty, "pop from empty queue")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(due_task) && $stable(last), "result changed while stalled")
    `ASSERT_NEXT(a_tick_step, clk, rst_n, bk_stat.tick_done, bk_stat.tick_count == $past(bk_stat.tick_count) + 32'd1, "tick count step")

endmodule
